// ===== hw/rtl/ssta_pkg.sv =====
// Package for the strided-slice tile address generator.
// Shared constants, register indexes and the face-layout function. No dependencies.
`timescale 1ns / 1ps
package ssta_pkg;
	localparam int MAX_RANK  = 4;
	localparam int TILE_SIDE = 32;
	localparam int FACE_SIDE = 16;
	localparam logic [31:0] NO_TILE = 32'hffff_ffff;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_SHAPE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_SHAPE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SHAPE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_OFFSETS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZES    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_GRID     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MODE_BITS     = 3'd6;

	typedef struct packed {
		logic [31:0] out_tile_id;
		logic [4:0]  elem_row;
		logic [4:0]  elem_col;
		logic        first_in_tile;
		logic        last_in_tile;
	} in_item_t;

	typedef struct packed {
		logic        in_extent;
		logic [31:0] source_tile;
		logic [9:0]  src_index;
		logic [9:0]  dest_index;
		logic        fetch_tile;
		logic        release_previous;
		logic        release_at_end;
	} out_item_t;

	// Face layout of a 32x32 tile: four 16x16 faces in row-major order.
	function automatic logic [9:0] face_index(input logic [4:0] r, input logic [4:0] c);
		face_index = {r[4], c[4], r[3:0], c[3:0]};
	endfunction

	// 16-bit slot k of a 64-bit register.
	function automatic logic [15:0] slot16(input logic [63:0] v, input logic [1:0] k);
		slot16 = v[16*k +: 16];
	endfunction
endpackage

// ===== hw/rtl/ssta_stream_if.sv =====
// Valid/ready channel interfaces carrying one item of the address generator.
// Depends on ssta_pkg for the input and result item types.
`timescale 1ns / 1ps
interface ssta_in_if;
	logic valid;
	logic ready;
	ssta_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ssta_out_if;
	logic valid;
	logic ready;
	ssta_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ssta_divider.sv =====
// Radix-2 restoring divider, 32 by 32 bits, one quotient bit per cycle.
// Zero divisor yields quotient all ones and remainder equal to the dividend.
`timescale 1ns / 1ps
module ssta_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient,
	output logic [31:0] remainder
);
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	// Shift in the next dividend bit and try a subtract
	always_comb begin
		shifted = {rem_q, quo_q[31]};
		trial   = shifted - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				quo_q  <= dividend;
				rem_q  <= '0;
				div_q  <= divisor;
			end else if (busy_q) begin
				if (trial[32]) begin
					rem_q <= shifted[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end else begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// Divide by zero naturally gives all-ones quotient and remainder = dividend
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

// ===== hw/rtl/strided_slice_tile_address_gen.sv =====
// Top level of the strided-slice tile address generator.
// Depends on ssta_pkg, ssta_stream_if and ssta_divider.
`timescale 1ns / 1ps
// Usage:
//  in  : one output element position per transaction (tile id, row, col,
//        first/last marks), valid/ready.
//  out : one result per input transaction, valid/ready.
//  cfg : write enable, register index, 64-bit data; write only while idle.
// Every division and remainder (tile decode, batch decode, slice decode) runs
// through one bit-serial divider; multiplies and adds go through one
// shared 32x32 multiply-add stage under a step sequencer.
// A rank-4 to rank-4 item takes 8 divides. An out-of-extent element runs
// the tile decode only.
// One item is in flight at a time; ready is high only when idle and the
// output register is free or being drained.
// Reset clears the configuration registers to zero, the cache to empty, and
// the sequencer to idle. A stalled receiver holds the result in the output
// register and the block takes no new item until it is taken.
module strided_slice_tile_address_gen (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ssta_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                 cfg_data,
	ssta_in_if.sink                     in_ch,
	ssta_out_if.source                  out_ch
);
	typedef enum logic [4:0] {
		ST_IDLE, ST_OMT, ST_DTILE, ST_DMT, ST_EXT, ST_BDIV, ST_BDIVW, ST_FLAT,
		ST_FLAT2, ST_FLAT3, ST_SDIV, ST_SDIVW, ST_SCMAP, ST_IB, ST_ST1, ST_ST2,
		ST_ST3, ST_CACHE
	} state_t;

	state_t state_q;
	logic [63:0] ishape_q, sshape_q, oshape_q, start_q, step_q, grid_q;
	logic [6:0]  mode_q;
	ssta_pkg::in_item_t item_q;
	logic [31:0] cached_q;
	logic        cvalid_q;
	logic        ovalid_q;
	ssta_pkg::out_item_t res_q;

	logic [2:0]  irank_q, orank_q;
	logic [31:0] omt_q, batch_q, rbase_q, cbase_q, flat_q, ib_q, stile_q, n_q;
	logic [31:0] bc_q [ssta_pkg::MAX_RANK];
	logic [31:0] sc_q [ssta_pkg::MAX_RANK];
	logic [2:0]  d_q;
	logic        inx_q;

	// Shared divider
	logic        dv_start;
	logic [31:0] dv_n, dv_d, dv_quo, dv_rem;
	logic        dv_done;
	logic        dv_pend_q;

	ssta_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_n),
		.divisor(dv_d), .done(dv_done), .quotient(dv_quo), .remainder(dv_rem)
	);

	// Shared multiply-add: ma_a * ma_b + ma_c, modulo 2^32
	logic [31:0] ma_a, ma_b, ma_c, ma_y, ma_prod;
	assign ma_prod = ma_a * ma_b;
	assign ma_y    = ma_prod + ma_c;

	// Rank decode, clamped
	logic [2:0] irank_c, orank_c;
	assign irank_c = (mode_q[2:0] > 3'(ssta_pkg::MAX_RANK)) ? 3'(ssta_pkg::MAX_RANK)
		: mode_q[2:0];
	assign orank_c = (mode_q[5:3] > 3'(ssta_pkg::MAX_RANK)) ? 3'(ssta_pkg::MAX_RANK)
		: mode_q[5:3];

	// Dimension d of a rank-r shape lives in slot r-1-d
	function automatic logic [31:0] dimv(input logic [63:0] v, input logic [2:0] r,
			input logic [2:0] d);
		logic [2:0] k;
		k = r - 3'd1 - d;
		dimv = (k > 3'd3) ? 32'd0 : {16'd0, ssta_pkg::slot16(v, k[1:0])};
	endfunction

	function automatic logic [31:0] ext(input logic [31:0] logical, input logic [31:0] base);
		logic [31:0] rem;
		rem = logical - base;
		if (base >= logical) ext = 32'd0;
		else ext = (rem < 32'd32) ? rem : 32'd32;
	endfunction

	logic [31:0] rcnt, ccnt, orow, ocol;
	always_comb begin
		rcnt = 32'd1;
		ccnt = 32'd1;
		if (orank_q == 3'd1) begin
			ccnt = ext(dimv(oshape_q, 3'd1, 3'd0), cbase_q);
		end else if (orank_q >= 3'd2) begin
			rcnt = ext(dimv(oshape_q, orank_q, orank_q - 3'd2), rbase_q);
			ccnt = ext(dimv(oshape_q, orank_q, orank_q - 3'd1), cbase_q);
		end
		orow = rbase_q + {27'd0, item_q.elem_row};
		ocol = cbase_q + {27'd0, item_q.elem_col};
	end

	// Two innermost slice coordinates
	logic [1:0]  ir_sel, ic_sel;
	logic [31:0] ir, ic;
	assign ir_sel = irank_q[1:0] - 2'd2;
	assign ic_sel = irank_q[1:0] - 2'd1;
	assign ir = sc_q[ir_sel];
	assign ic = sc_q[ic_sel];

	// Multiply-add operand select per state
	always_comb begin
		ma_a = 32'd0;
		ma_b = 32'd0;
		ma_c = 32'd0;
		case (state_q)
			ST_OMT: begin
				ma_a = {16'd0, grid_q[31:16]};
				ma_b = {16'd0, grid_q[15:0]};
			end
			ST_FLAT: begin
				ma_a = flat_q;
				ma_b = dimv(oshape_q, orank_q, d_q);
				ma_c = bc_q[d_q[1:0]];
			end
			ST_FLAT2: begin
				ma_a = flat_q;
				ma_b = mode_q[6] ? dimv(oshape_q, orank_q, orank_q - 3'd1)
					: dimv(oshape_q, orank_q, orank_q - 3'd2);
				ma_c = mode_q[6] ? ocol : orow;
			end
			ST_FLAT3: begin
				ma_a = flat_q;
				ma_b = mode_q[6] ? dimv(oshape_q, orank_q, orank_q - 3'd2)
					: dimv(oshape_q, orank_q, orank_q - 3'd1);
				ma_c = mode_q[6] ? orow : ocol;
			end
			ST_SCMAP: begin
				ma_a = sc_q[d_q[1:0]];
				ma_b = dimv(step_q, irank_q, d_q);
				ma_c = dimv(start_q, irank_q, d_q);
			end
			ST_IB: begin
				ma_a = ib_q;
				ma_b = dimv(ishape_q, irank_q, d_q);
				ma_c = sc_q[d_q[1:0]];
			end
			ST_ST1: begin
				ma_a = ib_q;
				ma_b = {16'd0, grid_q[63:48]};
				ma_c = {5'd0, ir[31:5]};
			end
			ST_ST2: begin
				ma_a = stile_q;
				ma_b = {16'd0, grid_q[47:32]};
				ma_c = {5'd0, ic[31:5]};
			end
			default: begin
			end
		endcase
	end

	// Divider operand select
	always_comb begin
		dv_start = 1'b0;
		dv_n = 32'd0;
		dv_d = 32'd0;
		case (state_q)
			ST_DTILE: begin
				dv_start = !dv_pend_q;
				dv_n = item_q.out_tile_id;
				dv_d = omt_q;
			end
			ST_DMT: begin
				dv_start = !dv_pend_q;
				dv_n = n_q;
				dv_d = {16'd0, grid_q[15:0]};
			end
			ST_BDIV: begin
				dv_start = 1'b1;
				dv_n = n_q;
				dv_d = dimv(oshape_q, orank_q, d_q - 3'd1);
			end
			ST_SDIV: begin
				dv_start = 1'b1;
				dv_n = flat_q;
				dv_d = dimv(sshape_q, irank_q, d_q - 3'd1);
			end
			default: begin
			end
		endcase
	end

	logic take_in;
	assign in_ch.ready  = (state_q == ST_IDLE) && (!ovalid_q || out_ch.ready);
	assign take_in      = in_ch.valid && in_ch.ready;
	assign out_ch.valid = ovalid_q;
	assign out_ch.data  = res_q;

	logic        cv_pre;
	logic [31:0] ct_pre;
	assign cv_pre = item_q.first_in_tile ? 1'b0 : cvalid_q;
	assign ct_pre = item_q.first_in_tile ? ssta_pkg::NO_TILE : cached_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ishape_q <= '0; sshape_q <= '0; oshape_q <= '0;
			start_q <= '0; step_q <= '0; grid_q <= '0; mode_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ssta_pkg::REG_INPUT_SHAPE:   ishape_q <= cfg_data;
				ssta_pkg::REG_SLICE_SHAPE:   sshape_q <= cfg_data;
				ssta_pkg::REG_OUTPUT_SHAPE:  oshape_q <= cfg_data;
				ssta_pkg::REG_START_OFFSETS: start_q <= cfg_data;
				ssta_pkg::REG_STEP_SIZES:    step_q <= cfg_data;
				ssta_pkg::REG_TILE_GRID:     grid_q <= cfg_data;
				ssta_pkg::REG_MODE_BITS:     mode_q <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer, cache and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ovalid_q  <= 1'b0;
			cached_q  <= ssta_pkg::NO_TILE;
			cvalid_q  <= 1'b0;
			dv_pend_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ch.ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take_in) begin
						item_q  <= in_ch.data;
						irank_q <= irank_c;
						orank_q <= orank_c;
						state_q <= ST_OMT;
					end
				end
				ST_OMT: begin
					omt_q   <= ma_y;
					state_q <= ST_DTILE;
				end
				ST_DTILE: begin
					dv_pend_q <= 1'b1;
					if (dv_done) begin
						dv_pend_q <= 1'b0;
						batch_q   <= dv_quo;
						n_q       <= dv_rem;
						state_q   <= ST_DMT;
					end
				end
				ST_DMT: begin
					dv_pend_q <= 1'b1;
					if (dv_done) begin
						dv_pend_q <= 1'b0;
						rbase_q   <= {dv_quo[26:0], 5'd0};
						cbase_q   <= {dv_rem[26:0], 5'd0};
						state_q   <= ST_EXT;
					end
				end
				ST_EXT: begin
					inx_q  <= ({27'd0, item_q.elem_row} < rcnt) &&
						({27'd0, item_q.elem_col} < ccnt);
					flat_q <= 32'd0;
					n_q    <= batch_q;
					if (!(({27'd0, item_q.elem_row} < rcnt) &&
						({27'd0, item_q.elem_col} < ccnt))) begin
						stile_q <= 32'd0;
						state_q <= ST_CACHE;
					end else if (orank_q == 3'd0) begin
						d_q <= irank_q;
						state_q <= (irank_q == 3'd0) ? ST_SCMAP : ST_SDIV;
					end else if (orank_q == 3'd1) begin
						flat_q  <= ocol;
						d_q     <= irank_q;
						state_q <= (irank_q == 3'd0) ? ST_SCMAP : ST_SDIV;
					end else begin
						d_q     <= orank_q - 3'd2;
						state_q <= (orank_q == 3'd2) ? ST_FLAT2 : ST_BDIV;
					end
				end
				// batch decode, innermost batch dim first
				ST_BDIV: state_q <= ST_BDIVW;
				ST_BDIVW: begin
					if (dv_done) begin
						bc_q[d_q[1:0] - 2'd1] <= dv_rem;
						n_q <= dv_quo;
						if (d_q == 3'd1) begin
							d_q     <= 3'd0;
							state_q <= ST_FLAT;
						end else begin
							d_q     <= d_q - 3'd1;
							state_q <= ST_BDIV;
						end
					end
				end
				ST_FLAT: begin
					flat_q <= ma_y;
					d_q    <= d_q + 3'd1;
					if (d_q + 3'd3 >= orank_q) state_q <= ST_FLAT2;
				end
				ST_FLAT2: begin
					flat_q  <= ma_y;
					state_q <= ST_FLAT3;
				end
				ST_FLAT3: begin
					flat_q  <= ma_y;
					d_q     <= irank_q;
					state_q <= (irank_q == 3'd0) ? ST_SCMAP : ST_SDIV;
				end
				// slice decode, innermost first
				ST_SDIV: state_q <= ST_SDIVW;
				ST_SDIVW: begin
					if (dv_done) begin
						sc_q[d_q[1:0] - 2'd1] <= dv_rem;
						flat_q <= dv_quo;
						if (d_q == 3'd1) begin
							d_q     <= 3'd0;
							state_q <= ST_SCMAP;
						end else begin
							d_q     <= d_q - 3'd1;
							state_q <= ST_SDIV;
						end
					end
				end
				ST_SCMAP: begin
					ib_q    <= 32'd0;
					stile_q <= 32'd0;
					if (d_q >= irank_q) begin
						d_q <= 3'd0;
						if (irank_q == 3'd1) begin
							stile_q <= {5'd0, sc_q[0][31:5]};
							state_q <= ST_CACHE;
						end else if (irank_q == 3'd0) begin
							state_q <= ST_CACHE;
						end else begin
							state_q <= (irank_q == 3'd2) ? ST_ST1 : ST_IB;
						end
					end else begin
						sc_q[d_q[1:0]] <= ma_y;
						d_q <= d_q + 3'd1;
					end
				end
				ST_IB: begin
					ib_q <= ma_y;
					d_q  <= d_q + 3'd1;
					if (d_q + 3'd3 >= irank_q) state_q <= ST_ST1;
				end
				ST_ST1: begin
					stile_q <= ma_y;
					state_q <= ST_ST2;
				end
				ST_ST2: begin
					stile_q <= ma_y;
					state_q <= ST_CACHE;
				end
				ST_CACHE: begin
					res_q.in_extent    <= inx_q;
					res_q.source_tile  <= inx_q ? stile_q : 32'd0;
					res_q.dest_index   <= ssta_pkg::face_index(item_q.elem_row, item_q.elem_col);
					res_q.src_index    <= 10'd0;
					if (inx_q && irank_q == 3'd1)
						res_q.src_index <= ssta_pkg::face_index(5'd0, sc_q[0][4:0]);
					else if (inx_q && irank_q >= 3'd2)
						res_q.src_index <= ssta_pkg::face_index(ir[4:0], ic[4:0]);
					res_q.fetch_tile       <= 1'b0;
					res_q.release_previous <= 1'b0;
					cvalid_q <= cv_pre;
					cached_q <= ct_pre;
					if (inx_q && (!cv_pre || ct_pre != stile_q)) begin
						res_q.fetch_tile       <= 1'b1;
						res_q.release_previous <= cv_pre;
						cvalid_q <= 1'b1;
						cached_q <= stile_q;
					end
					res_q.release_at_end <= item_q.last_in_tile && (cv_pre || inx_q);
					if (item_q.last_in_tile) begin
						cvalid_q <= 1'b0;
						cached_q <= ssta_pkg::NO_TILE;
					end
					ovalid_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Checks
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ch.ready)
		else $error("input accepted while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !out_ch.ready) |=> ovalid_q)
		else $error("result dropped under stall");
	a_fetch_inx: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> (!res_q.fetch_tile || res_q.in_extent))
		else $error("fetch outside extent");
	a_rel_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> (!res_q.release_previous || res_q.fetch_tile))
		else $error("release without fetch");
endmodule
